// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the mirrored tree traversal unit.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MTT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mtt assertion failed");

// Next-cycle implication, disabled while rst is high.
`define MTT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mtt assertion failed");

`endif

// ----- rtl/mtt_pkg.sv -----
// Types, codes and microcode program of the mirrored tree traversal unit.
// No dependencies; used by the sequencer, the top level and the checker.
`timescale 1ns / 1ps

package mtt_pkg;

   localparam int NODE_W = 5;
   localparam int CSR_W  = 6;
   localparam int LINK_W = 6;
   localparam int UPC_W  = 5;

   localparam logic [CSR_W-1:0] CSR_RESET = 6'd1;

   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_RUN    = 1'b1;
   localparam logic ORDER_LEVEL = 1'b0;
   localparam logic ORDER_IN    = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [NODE_W-1:0] node_index;
      logic              left_present;
      logic [NODE_W-1:0] left_child;
      logic              right_present;
      logic [NODE_W-1:0] right_child;
   } req_word_type;

   typedef struct packed {
      logic [NODE_W-1:0] node_id;
      logic              order_kind;
      logic              last;
      logic              no_root;
   } rsp_word_type;

   typedef enum logic [4:0] {
      OP_IDLE,
      OP_NOP,
      OP_SWEEP_RD,
      OP_MARK,
      OP_CLR_I,
      OP_SCAN_NEXT,
      OP_LVL_INIT,
      OP_QRD,
      OP_LVL_TAKE,
      OP_LVL_EMIT,
      OP_PUSH_L,
      OP_IN_INIT,
      OP_PUSH_CUR,
      OP_GO_RIGHT,
      OP_STK_RD,
      OP_POP_TAKE,
      OP_IN_EMIT,
      OP_FLUSH,
      OP_NOROOT
   } op_type;

   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_NOT_RUN,
      C_I_DONE,
      C_MARKED,
      C_LVL_DONE,
      C_IN_DONE,
      C_NO_DESC,
      C_STK_EMPTY
   } cond_type;

   typedef struct packed {
      op_type           op;
      cond_type         cond;
      logic [UPC_W-1:0] target;
   } ucode_type;

   typedef struct packed {
      logic not_run;
      logic i_done;
      logic marked;
      logic lvl_done;
      logic in_done;
      logic no_desc;
      logic stk_empty;
      logic stall;
   } mtt_flags_type;

   // Step addresses of the program.
   localparam logic [UPC_W-1:0] S_IDLE       = 5'd0;
   localparam logic [UPC_W-1:0] S_SWEEP      = 5'd1;
   localparam logic [UPC_W-1:0] S_MARK       = 5'd2;
   localparam logic [UPC_W-1:0] S_SCAN_INIT  = 5'd3;
   localparam logic [UPC_W-1:0] S_SCAN       = 5'd4;
   localparam logic [UPC_W-1:0] S_SCAN_NEXT  = 5'd5;
   localparam logic [UPC_W-1:0] S_LVL_INIT   = 5'd6;
   localparam logic [UPC_W-1:0] S_LVL_POP    = 5'd7;
   localparam logic [UPC_W-1:0] S_LVL_TAKE   = 5'd8;
   localparam logic [UPC_W-1:0] S_LVL_EMIT   = 5'd9;
   localparam logic [UPC_W-1:0] S_LVL_PUSH_L = 5'd10;
   localparam logic [UPC_W-1:0] S_IN_INIT    = 5'd11;
   localparam logic [UPC_W-1:0] S_IN_CHK     = 5'd12;
   localparam logic [UPC_W-1:0] S_DESC       = 5'd13;
   localparam logic [UPC_W-1:0] S_DESC_NEXT  = 5'd14;
   localparam logic [UPC_W-1:0] S_POP        = 5'd15;
   localparam logic [UPC_W-1:0] S_POP_TAKE   = 5'd16;
   localparam logic [UPC_W-1:0] S_IN_EMIT    = 5'd17;
   localparam logic [UPC_W-1:0] S_FLUSH      = 5'd18;
   localparam logic [UPC_W-1:0] S_NOROOT     = 5'd19;

   // Program ROM: jump to target when the condition holds, else fall through.
   function automatic ucode_type ucode_rom(input logic [UPC_W-1:0] addr);
      ucode_type cw;
      case (addr)
         S_IDLE:       cw = '{OP_IDLE,      C_NOT_RUN,   S_IDLE};
         S_SWEEP:      cw = '{OP_SWEEP_RD,  C_I_DONE,    S_SCAN_INIT};
         S_MARK:       cw = '{OP_MARK,      C_ALWAYS,    S_SWEEP};
         S_SCAN_INIT:  cw = '{OP_CLR_I,     C_NEVER,     S_IDLE};
         S_SCAN:       cw = '{OP_NOP,       C_I_DONE,    S_NOROOT};
         S_SCAN_NEXT:  cw = '{OP_SCAN_NEXT, C_MARKED,    S_SCAN};
         S_LVL_INIT:   cw = '{OP_LVL_INIT,  C_NEVER,     S_IDLE};
         S_LVL_POP:    cw = '{OP_QRD,       C_LVL_DONE,  S_IN_INIT};
         S_LVL_TAKE:   cw = '{OP_LVL_TAKE,  C_NEVER,     S_IDLE};
         S_LVL_EMIT:   cw = '{OP_LVL_EMIT,  C_NEVER,     S_IDLE};
         S_LVL_PUSH_L: cw = '{OP_PUSH_L,    C_ALWAYS,    S_LVL_POP};
         S_IN_INIT:    cw = '{OP_IN_INIT,   C_NEVER,     S_IDLE};
         S_IN_CHK:     cw = '{OP_NOP,       C_IN_DONE,   S_FLUSH};
         S_DESC:       cw = '{OP_PUSH_CUR,  C_NO_DESC,   S_POP};
         S_DESC_NEXT:  cw = '{OP_GO_RIGHT,  C_ALWAYS,    S_DESC};
         S_POP:        cw = '{OP_STK_RD,    C_STK_EMPTY, S_FLUSH};
         S_POP_TAKE:   cw = '{OP_POP_TAKE,  C_NEVER,     S_IDLE};
         S_IN_EMIT:    cw = '{OP_IN_EMIT,   C_ALWAYS,    S_IN_CHK};
         S_FLUSH:      cw = '{OP_FLUSH,     C_ALWAYS,    S_IDLE};
         S_NOROOT:     cw = '{OP_NOROOT,    C_ALWAYS,    S_IDLE};
         default:      cw = '{OP_NOP,       C_ALWAYS,    S_IDLE};
      endcase
      return cw;
   endfunction

endpackage

// ----- rtl/mirrored_tree_traversal_unit.sv -----
// Mirrored tree traversal: a load writes one node's links into the link table; a run
// sweeps the links to find the root, then emits the nodes in level order and then
// in-order. Requests are taken only while idle. The microcode takes one step per
// cycle unless the output stalls, and the link table has a single read port.
// Reset (synchronous, active high) returns to idle, node_count to 1 and drops any
// queued result; the link table stays undefined until loaded.
`timescale 1ns / 1ps

module mirrored_tree_traversal_unit #(
   parameter int MAX_NODES = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  mtt_pkg::req_word_type         req_word,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output mtt_pkg::rsp_word_type         rsp_word,
   input  logic                          csr_wr_en,
   input  logic [mtt_pkg::CSR_W-1:0]     csr_wr_data
);

   localparam int IW   = $clog2(MAX_NODES);     // node address bits
   localparam int CW   = $clog2(MAX_NODES + 1); // counts up to MAX_NODES
   localparam int NW   = mtt_pkg::NODE_W;
   localparam int CSRW = mtt_pkg::CSR_W;
   localparam int LW   = mtt_pkg::LINK_W;

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   mtt_pkg::ucode_type     ctl;
   mtt_pkg::mtt_flags_type flags;

   mtt_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctl   (ctl)
   );

   // ---------------------------------------------------------------
   // State
   // ---------------------------------------------------------------
   logic [CSRW-1:0]      csr_ff,        csr_in;
   logic [CW-1:0]        cnt_ff,        cnt_in;
   logic [CW-1:0]        i_ff,          i_in;
   logic [MAX_NODES-1:0] marks_ff,      marks_in;
   logic [NW-1:0]        root_ff,       root_in;
   logic [NW-1:0]        cur_ff,        cur_in;
   logic                 cur_ok_ff,     cur_ok_in;
   logic [IW-1:0]        head_ff,       head_in;
   logic [CW-1:0]        size_ff,       size_in;
   logic [CW-1:0]        emitted_ff,    emitted_in;
   logic [CW-1:0]        depth_ff,      depth_in;
   mtt_pkg::rsp_word_type pend_ff,      pend_in;
   logic                 pend_valid_ff, pend_valid_in;
   mtt_pkg::rsp_word_type rsp_ff,       rsp_in;
   logic                 rsp_valid_ff,  rsp_valid_in;

   // ---------------------------------------------------------------
   // Link table: left link in the upper half, right link in the lower
   // ---------------------------------------------------------------
   logic              link_wr_en;
   logic [IW-1:0]     link_wr_addr;
   logic [2*LW-1:0]   link_wr_data;
   logic              link_rd_en;
   logic [IW-1:0]     link_rd_addr;
   logic [2*LW-1:0]   link_rd;

   mtt_ram #(
      .WIDTH (2 * LW),
      .DEPTH (MAX_NODES)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_en   (link_rd_en),
      .rd_addr (link_rd_addr),
      .rd_data (link_rd)
   );

   // Work memory: queue during level order, stack during in-order
   logic          work_wr_en;
   logic [IW-1:0] work_wr_addr;
   logic [NW-1:0] work_wr_data;
   logic          work_rd_en;
   logic [IW-1:0] work_rd_addr;
   logic [NW-1:0] work_rd;

   mtt_ram #(
      .WIDTH (NW),
      .DEPTH (MAX_NODES)
   ) u_work_ram (
      .clock   (clock),
      .wr_en   (work_wr_en),
      .wr_addr (work_wr_addr),
      .wr_data (work_wr_data),
      .rd_en   (work_rd_en),
      .rd_addr (work_rd_addr),
      .rd_data (work_rd)
   );

   // ---------------------------------------------------------------
   // Datapath helpers
   // ---------------------------------------------------------------
   logic            req_acc, run_acc, load_acc;
   logic            out_free, is_emit, stall;
   logic [LW-1:0]   lft_link, rgt_link;
   logic            lft_ok, rgt_ok;
   logic [CSRW-1:0] cnt_ext;
   logic [CW:0]     tail_sum, tail_wrap;
   logic [IW-1:0]   tail_idx, head_next;
   logic [CW-1:0]   depth_dec;
   logic            q_room;

   assign req_ready = (ctl.op == mtt_pkg::OP_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign run_acc   = req_acc && (req_word.kind == mtt_pkg::KIND_RUN);
   assign load_acc  = req_acc && (req_word.kind == mtt_pkg::KIND_LOAD);

   // a result register slot is free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign is_emit  = (ctl.op == mtt_pkg::OP_LVL_EMIT) || (ctl.op == mtt_pkg::OP_IN_EMIT);
   assign stall    = (is_emit && pend_valid_ff && !out_free) ||
                     (((ctl.op == mtt_pkg::OP_FLUSH) || (ctl.op == mtt_pkg::OP_NOROOT))
                      && !out_free);

   // children at or above the node count read as absent
   assign cnt_ext  = CSRW'(cnt_ff);
   assign lft_link = link_rd[2*LW-1:LW];
   assign rgt_link = link_rd[LW-1:0];
   assign lft_ok   = lft_link[LW-1] && ({1'b0, lft_link[NW-1:0]} < cnt_ext);
   assign rgt_ok   = rgt_link[LW-1] && ({1'b0, rgt_link[NW-1:0]} < cnt_ext);

   // queue tail = (head + size) mod MAX_NODES, with sum below twice the depth
   assign tail_sum  = (CW+1)'(head_ff) + (CW+1)'(size_ff);
   assign tail_wrap = (tail_sum >= (CW+1)'(MAX_NODES)) ? tail_sum - (CW+1)'(MAX_NODES)
                                                       : tail_sum;
   assign tail_idx  = tail_wrap[IW-1:0];
   assign head_next = (head_ff == IW'(MAX_NODES - 1)) ? '0 : head_ff + 1'b1;
   assign q_room    = (size_ff < CW'(MAX_NODES));
   assign depth_dec = depth_ff - 1'b1;

   // status back to the sequencer
   always_comb begin
      flags.not_run   = !run_acc;
      flags.i_done    = (i_ff >= cnt_ff);
      flags.marked    = marks_ff[i_ff[IW-1:0]];
      flags.lvl_done  = (size_ff == '0) || (emitted_ff >= cnt_ff);
      flags.in_done   = (emitted_ff >= cnt_ff);
      flags.no_desc   = !cur_ok_ff || (depth_ff >= CW'(MAX_NODES));
      flags.stk_empty = (depth_ff == '0);
      flags.stall     = stall;
   end

   // ---------------------------------------------------------------
   // Datapath control per microcode op
   // ---------------------------------------------------------------
   always_comb begin
      csr_in        = csr_ff;
      cnt_in        = cnt_ff;
      i_in          = i_ff;
      marks_in      = marks_ff;
      root_in       = root_ff;
      cur_in        = cur_ff;
      cur_ok_in     = cur_ok_ff;
      head_in       = head_ff;
      size_in       = size_ff;
      emitted_in    = emitted_ff;
      depth_in      = depth_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      link_wr_en    = 1'b0;
      link_wr_addr  = req_word.node_index[IW-1:0];
      link_wr_data  = {req_word.left_present, req_word.left_child,
                       req_word.right_present, req_word.right_child};
      link_rd_en    = 1'b0;
      link_rd_addr  = i_ff[IW-1:0];
      work_wr_en    = 1'b0;
      work_wr_addr  = tail_idx;
      work_wr_data  = cur_ff;
      work_rd_en    = 1'b0;
      work_rd_addr  = head_ff;

      if (csr_wr_en) begin
         csr_in = csr_wr_data;
      end

      // drop loads beyond the table
      if (load_acc && ({1'b0, req_word.node_index} < CSRW'(MAX_NODES))) begin
         link_wr_en = 1'b1;
      end

      // an emit pushes the held result out and holds the new one, so the
      // final result can still get its last flag
      if (is_emit && !stall) begin
         if (pend_valid_ff) begin
            rsp_in       = pend_ff;
            rsp_valid_in = 1'b1;
         end
         pend_in.node_id    = cur_ff;
         pend_in.order_kind = (ctl.op == mtt_pkg::OP_IN_EMIT) ? mtt_pkg::ORDER_IN
                                                               : mtt_pkg::ORDER_LEVEL;
         pend_in.last       = 1'b0;
         pend_in.no_root    = 1'b0;
         pend_valid_in      = 1'b1;
         emitted_in         = emitted_ff + 1'b1;
      end

      if (!stall) begin
         case (ctl.op)
            mtt_pkg::OP_IDLE: begin
               if (run_acc) begin
                  cnt_in        = (csr_ff > CSRW'(MAX_NODES)) ? CW'(MAX_NODES)
                                                              : csr_ff[CW-1:0];
                  i_in          = '0;
                  marks_in      = '0;
                  pend_valid_in = 1'b0;
               end
            end
            mtt_pkg::OP_SWEEP_RD: begin
               link_rd_en   = 1'b1;
               link_rd_addr = i_ff[IW-1:0];
            end
            mtt_pkg::OP_MARK: begin
               if (lft_ok) begin
                  marks_in[lft_link[IW-1:0]] = 1'b1;
               end
               if (rgt_ok) begin
                  marks_in[rgt_link[IW-1:0]] = 1'b1;
               end
               i_in = i_ff + 1'b1;
            end
            mtt_pkg::OP_CLR_I: begin
               i_in = '0;
            end
            mtt_pkg::OP_SCAN_NEXT: begin
               root_in = NW'(i_ff);
               i_in    = i_ff + 1'b1;
            end
            mtt_pkg::OP_LVL_INIT: begin
               work_wr_en   = 1'b1;
               work_wr_addr = '0;
               work_wr_data = root_ff;
               head_in      = '0;
               size_in      = CW'(1);
               emitted_in   = '0;
            end
            mtt_pkg::OP_QRD: begin
               work_rd_en   = 1'b1;
               work_rd_addr = head_ff;
            end
            mtt_pkg::OP_LVL_TAKE: begin
               cur_in       = work_rd;
               link_rd_en   = 1'b1;
               link_rd_addr = work_rd[IW-1:0];
               head_in      = head_next;
               size_in      = size_ff - 1'b1;
            end
            mtt_pkg::OP_LVL_EMIT: begin
               // mirror: right child enters the queue first
               if (rgt_ok && q_room) begin
                  work_wr_en   = 1'b1;
                  work_wr_addr = tail_idx;
                  work_wr_data = rgt_link[NW-1:0];
                  size_in      = size_ff + 1'b1;
               end
            end
            mtt_pkg::OP_PUSH_L: begin
               if (lft_ok && q_room) begin
                  work_wr_en   = 1'b1;
                  work_wr_addr = tail_idx;
                  work_wr_data = lft_link[NW-1:0];
                  size_in      = size_ff + 1'b1;
               end
            end
            mtt_pkg::OP_IN_INIT: begin
               cur_in     = root_ff;
               cur_ok_in  = 1'b1;
               depth_in   = '0;
               emitted_in = '0;
            end
            mtt_pkg::OP_PUSH_CUR: begin
               if (!flags.no_desc) begin
                  work_wr_en   = 1'b1;
                  work_wr_addr = depth_ff[IW-1:0];
                  work_wr_data = cur_ff;
                  depth_in     = depth_ff + 1'b1;
                  link_rd_en   = 1'b1;
                  link_rd_addr = cur_ff[IW-1:0];
               end
            end
            mtt_pkg::OP_GO_RIGHT: begin
               cur_in    = rgt_link[NW-1:0];
               cur_ok_in = rgt_ok;
            end
            mtt_pkg::OP_STK_RD: begin
               if (!flags.stk_empty) begin
                  work_rd_en   = 1'b1;
                  work_rd_addr = depth_dec[IW-1:0];
                  depth_in     = depth_dec;
               end
            end
            mtt_pkg::OP_POP_TAKE: begin
               cur_in       = work_rd;
               link_rd_en   = 1'b1;
               link_rd_addr = work_rd[IW-1:0];
            end
            mtt_pkg::OP_IN_EMIT: begin
               // after the node, descend into the left (mirrored) subtree
               cur_in    = lft_link[NW-1:0];
               cur_ok_in = lft_ok;
            end
            mtt_pkg::OP_FLUSH: begin
               rsp_in        = pend_ff;
               rsp_in.last   = 1'b1;
               rsp_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
            end
            mtt_pkg::OP_NOROOT: begin
               rsp_in.node_id    = '0;
               rsp_in.order_kind = mtt_pkg::ORDER_LEVEL;
               rsp_in.last       = 1'b1;
               rsp_in.no_root    = 1'b1;
               rsp_valid_in      = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff        <= mtt_pkg::CSR_RESET;
         cnt_ff        <= '0;
         i_ff          <= '0;
         marks_ff      <= '0;
         cur_ok_ff     <= 1'b0;
         head_ff       <= '0;
         size_ff       <= '0;
         emitted_ff    <= '0;
         depth_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         csr_ff        <= csr_in;
         cnt_ff        <= cnt_in;
         i_ff          <= i_in;
         marks_ff      <= marks_in;
         cur_ok_ff     <= cur_ok_in;
         head_ff       <= head_in;
         size_ff       <= size_in;
         emitted_ff    <= emitted_in;
         depth_ff      <= depth_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload holds need no reset
   always_ff @(posedge clock) begin
      root_ff <= root_in;
      cur_ff  <= cur_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

// ----- rtl/mtt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mtt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold read data while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/mtt_seq.sv -----
// Microcode sequencer: step counter, program ROM and conditional jumps.
// Depends on mtt_pkg.
`timescale 1ns / 1ps

module mtt_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  mtt_pkg::mtt_flags_type flags,
   output mtt_pkg::ucode_type     ctl
);

   logic [mtt_pkg::UPC_W-1:0] upc_ff;
   logic [mtt_pkg::UPC_W-1:0] upc_in;
   logic                      take_jump;

   assign ctl = mtt_pkg::ucode_rom(upc_ff);

   always_comb begin
      case (ctl.cond)
         mtt_pkg::C_NEVER:     take_jump = 1'b0;
         mtt_pkg::C_ALWAYS:    take_jump = 1'b1;
         mtt_pkg::C_NOT_RUN:   take_jump = flags.not_run;
         mtt_pkg::C_I_DONE:    take_jump = flags.i_done;
         mtt_pkg::C_MARKED:    take_jump = flags.marked;
         mtt_pkg::C_LVL_DONE:  take_jump = flags.lvl_done;
         mtt_pkg::C_IN_DONE:   take_jump = flags.in_done;
         mtt_pkg::C_NO_DESC:   take_jump = flags.no_desc;
         mtt_pkg::C_STK_EMPTY: take_jump = flags.stk_empty;
         default:              take_jump = 1'b0;
      endcase

      // hold the step while the output side backs up
      if (flags.stall) begin
         upc_in = upc_ff;
      end else if (take_jump) begin
         upc_in = ctl.target;
      end else begin
         upc_in = upc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= mtt_pkg::S_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

// ----- rtl/mtt_checker.sv -----
// Port-level checker for the mirrored tree traversal unit, bound to its top level.
// Depends on mtt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mtt_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input mtt_pkg::req_word_type req_word,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input mtt_pkg::rsp_word_type rsp_word
);

   // a stalled result word holds
   `MTT_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))

   // a no-root word is the whole run: node 0, level order, last
   `MTT_ASSERT_IMP(a_noroot_form, clock, reset, rsp_valid && rsp_word.no_root, rsp_word.last && (rsp_word.node_id == '0) && (rsp_word.order_kind == mtt_pkg::ORDER_LEVEL))

   // no new item is taken while a run still has words to give
   `MTT_ASSERT_IMP(a_busy_run, clock, reset, rsp_valid && !rsp_word.last, !req_ready)

   // reset leaves no word pending
   `MTT_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind mirrored_tree_traversal_unit mtt_checker u_mtt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);
